### hw/rtl/act_pkg.sv
// act_pkg: shared constants for the ancestry call tally block
// sizes of the count table, memory row layout and result status codes
// no dependencies
package act_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int SAMPLE_BITS    = $clog2(MAX_SAMPLES);
  localparam int NUM_ANCESTRIES = 8;
  localparam int ANC_BITS       = $clog2(NUM_ANCESTRIES);
  localparam int COUNT_BITS     = 32;
  localparam int TOT_BITS       = COUNT_BITS + 1;
  localparam int SITE_BITS      = 32;
  localparam int ROW_BITS       = NUM_ANCESTRIES * COUNT_BITS;
  localparam int LANE_IDX_BITS  = $clog2(ROW_BITS);
  localparam int MEM_BITS       = ROW_BITS + TOT_BITS;

  localparam int THIN_BITS      = 16;
  localparam int LIM_BITS       = 4;
  localparam int CALL_BITS      = 5;

  localparam int IN_BITS        = 24;
  localparam int OUT_BITS       = 168;

  localparam logic [2:0] ST_COUNTED  = 3'd0;
  localparam logic [2:0] ST_MISSING  = 3'd1;
  localparam logic [2:0] ST_THINNED  = 3'd2;
  localparam logic [2:0] ST_ROW_ABS  = 3'd3;
  localparam logic [2:0] ST_TOO_BIG  = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;

  localparam logic [1:0] REG_THIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_ANC_IN_USE    = 2'd1;

endpackage

### hw/rtl/ancestry_call_tally_top.sv
// ancestry_call_tally_top: per-sample, per-ancestry allele tally
// depends on act_pkg and act_ram (one row per sample: all counts plus total)
//
// usage:
//   s_* carries one call item (tally) or one query (read); m_* returns one
//   result item per input item; cfg_* writes thin_interval (index 0) and
//   ancestries_in_use (index 1) and is always ready; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   an accepted item reads its sample's row from the table ram (registered
//   read); once the output register is free, the block updates the row,
//   writes it back and loads the output register. a new item is accepted
//   only after the current item's update is done.
//   after reset the table ram is cleared one row per cycle, all MAX_SAMPLES
//   (1024) rows, with s_tready low; config writes are taken meanwhile.
//   when the receiver stalls, the finished result waits in the output
//   register; one more item may be accepted and read, and its update waits
//   until the output register frees.
module ancestry_call_tally_top
  import act_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // record_start, row_present, sample_index[9:0], first_ancestry[4:0],
  // second_ancestry[4:0], zero pad
  input  logic [IN_BITS-1:0]  s_tdata,
  // mode
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // allele_count[31:0], called_total[32:0], sites_seen[31:0], sites_used[31:0],
  // skipped_calls[31:0], zero pad
  output logic [OUT_BITS-1:0] m_tdata,
  // status[2:0]
  output logic [2:0]          m_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WORK  = 2'd2;

  logic [1:0]             state;
  logic [SAMPLE_BITS-1:0] clr_addr;

  logic [THIN_BITS-1:0]   thin_interval;
  logic [LIM_BITS-1:0]    anc_in_use;

  logic [SITE_BITS-1:0]   sites_seen;
  logic [SITE_BITS-1:0]   sites_used;
  logic [SITE_BITS-1:0]   skipped;
  logic [THIN_BITS-1:0]   thin_phase;
  logic                   site_in_use;

  logic                   q_mode;
  logic                   q_start;
  logic                   q_row;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic [CALL_BITS-1:0]   q_first;
  logic [CALL_BITS-1:0]   q_second;

  logic                   out_valid;
  logic [2:0]             out_status;
  logic [COUNT_BITS-1:0]  out_count;
  logic [TOT_BITS-1:0]    out_total;
  logic [SITE_BITS-1:0]   out_seen;
  logic [SITE_BITS-1:0]   out_used;
  logic [SITE_BITS-1:0]   out_skipped;

  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_waddr;
  logic [MEM_BITS-1:0]    ram_wdata;
  logic                   ram_re;
  logic [MEM_BITS-1:0]    ram_rdata;

  logic                   in_fire;
  logic                   work_fire;

  logic [2:0]             status_next;
  logic [COUNT_BITS-1:0]  count_next;
  logic [TOT_BITS-1:0]    total_next;
  logic [SITE_BITS-1:0]   sites_seen_next;
  logic [SITE_BITS-1:0]   sites_used_next;
  logic [SITE_BITS-1:0]   skipped_next;
  logic [THIN_BITS-1:0]   thin_phase_next;
  logic                   site_in_use_next;
  logic                   row_write;
  logic [ROW_BITS-1:0]    row_new;

  function automatic logic [SITE_BITS-1:0] sat_inc(input logic [SITE_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + SITE_BITS'(1);
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign work_fire = (state == S_WORK) && (!out_valid || m_tready);

  assign ram_re    = in_fire;
  assign ram_we    = (state == S_CLEAR) || (work_fire && row_write);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : q_sample;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {total_next, row_new};

  act_ram #(
    .WIDTH(MEM_BITS),
    .DEPTH(MAX_SAMPLES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(s_tdata[11:2]),
    .rdata(ram_rdata)
  );

  always_comb begin
    logic [ROW_BITS-1:0]   row_old;
    logic [TOT_BITS-1:0]   tot_old;
    logic [TOT_BITS:0]     tot_sum;
    logic [COUNT_BITS:0]   lane_sum;
    logic [1:0]            lane_inc;
    logic [ANC_BITS-1:0]   a1i;
    logic [ANC_BITS-1:0]   a2i;
    logic [LANE_IDX_BITS-1:0] lane_lo;
    logic [LIM_BITS-1:0]   a1;
    logic [LIM_BITS-1:0]   a2;
    logic                  neg1;
    logic                  neg2;
    logic [LIM_BITS-1:0]   lim;
    logic [THIN_BITS-1:0]  ti;
    logic [THIN_BITS:0]    phase_inc;
    logic                  sample_ok;
    logic                  first_site;
    row_old   = ram_rdata[ROW_BITS-1:0];
    tot_old   = ram_rdata[MEM_BITS-1:ROW_BITS];
    neg1      = q_first[CALL_BITS-1];
    neg2      = q_second[CALL_BITS-1];
    a1        = q_first[LIM_BITS-1:0];
    a2        = q_second[LIM_BITS-1:0];
    a1i       = q_first[ANC_BITS-1:0];
    a2i       = q_second[ANC_BITS-1:0];
    lane_lo   = LANE_IDX_BITS'(a1i * COUNT_BITS);
    lim       = (anc_in_use > LIM_BITS'(NUM_ANCESTRIES)) ? LIM_BITS'(NUM_ANCESTRIES)
                                                         : anc_in_use;
    ti        = (thin_interval == '0) ? THIN_BITS'(1) : thin_interval;
    sample_ok = ((SAMPLE_BITS + 1)'(q_sample) < (SAMPLE_BITS + 1)'(MAX_SAMPLES));

    for (int k = 0; k < NUM_ANCESTRIES; k++) begin
      lane_inc = {1'b0, (a1i == ANC_BITS'(k))} + {1'b0, (a2i == ANC_BITS'(k))};
      lane_sum = {1'b0, row_old[k*COUNT_BITS +: COUNT_BITS]} + (COUNT_BITS + 1)'(lane_inc);
      row_new[k*COUNT_BITS +: COUNT_BITS] = lane_sum[COUNT_BITS] ? '1
                                          : lane_sum[COUNT_BITS-1:0];
    end
    tot_sum = {1'b0, tot_old} + (TOT_BITS + 1)'(2);

    sites_seen_next  = sites_seen;
    sites_used_next  = sites_used;
    skipped_next     = skipped;
    thin_phase_next  = thin_phase;
    site_in_use_next = site_in_use;
    row_write        = 1'b0;
    total_next       = tot_old;
    count_next       = '0;
    first_site       = (thin_phase == '0);
    phase_inc        = {1'b0, thin_phase} + (THIN_BITS + 1)'(1);

    if (q_mode) begin
      if (!neg1 && (a1 < lim) && sample_ok) begin
        status_next = ST_READ;
        count_next  = row_old[lane_lo +: COUNT_BITS];
      end else begin
        status_next = ST_TOO_BIG;
      end
    end else begin
      if (q_start) begin
        sites_seen_next  = sat_inc(sites_seen);
        site_in_use_next = first_site && q_row;
        if (first_site && q_row) begin
          sites_used_next = sat_inc(sites_used);
        end
        thin_phase_next = (phase_inc >= {1'b0, ti}) ? '0 : phase_inc[THIN_BITS-1:0];
      end
      priority if (!site_in_use_next) begin
        status_next = ((ti > THIN_BITS'(1)) && (thin_phase_next != THIN_BITS'(1)))
                    ? ST_THINNED : ST_ROW_ABS;
      end else if (neg1 || neg2) begin
        status_next  = ST_MISSING;
        skipped_next = sat_inc(skipped);
      end else if ((a1 >= lim) || (a2 >= lim) || !sample_ok) begin
        status_next  = ST_TOO_BIG;
        skipped_next = sat_inc(skipped);
      end else begin
        status_next = ST_COUNTED;
        row_write   = 1'b1;
        total_next  = tot_sum[TOT_BITS] ? '1 : tot_sum[TOT_BITS-1:0];
        count_next  = row_new[lane_lo +: COUNT_BITS];
      end
    end
    if (!sample_ok) begin
      total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      thin_interval <= THIN_BITS'(1);
      anc_in_use    <= LIM_BITS'(8);
      sites_seen    <= '0;
      sites_used    <= '0;
      skipped       <= '0;
      thin_phase    <= '0;
      site_in_use   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_THIN_INTERVAL: thin_interval <= cfg_data[THIN_BITS-1:0];
          REG_ANC_IN_USE:    anc_in_use    <= cfg_data[LIM_BITS-1:0];
          default: ;
        endcase
      end

      if (work_fire) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SAMPLE_BITS'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (work_fire) begin
            state       <= S_IDLE;
            sites_seen  <= sites_seen_next;
            sites_used  <= sites_used_next;
            skipped     <= skipped_next;
            thin_phase  <= thin_phase_next;
            site_in_use <= site_in_use_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_mode   <= s_tuser;
      q_start  <= s_tdata[0];
      q_row    <= s_tdata[1];
      q_sample <= s_tdata[11:2];
      q_first  <= s_tdata[16:12];
      q_second <= s_tdata[21:17];
    end
    if (work_fire) begin
      out_status  <= status_next;
      out_count   <= count_next;
      out_total   <= total_next;
      out_seen    <= sites_seen_next;
      out_used    <= sites_used_next;
      out_skipped <= skipped_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_skipped, out_used, out_seen, out_total, out_count};

endmodule

### hw/rtl/act_ram.sv
// act_ram: generic single-write, single-read synchronous ram
// read data registered; holds when no read is issued
// no dependencies
module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sim/tb_ancestry_call_tally_top.sv
// testbench for ancestry_call_tally_top: directed and random call/read items
// against an in-bench tally predictor, with random stalls on both streams
// depends on act_pkg and the ancestry_call_tally_top rtl
`timescale 1ns / 1ps

module tb_ancestry_call_tally_top;
  import act_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 165;
  localparam int CNT_IDX_BITS = $clog2(MAX_SAMPLES * NUM_ANCESTRIES);

  typedef struct {
    logic [2:0]            status;
    logic [COUNT_BITS-1:0] count;
    logic [TOT_BITS-1:0]   total;
    logic [SITE_BITS-1:0]  seen;
    logic [SITE_BITS-1:0]  used;
    logic [SITE_BITS-1:0]  skipped;
  } tally_result_t;

  class tally_scoreboard;
    logic [COUNT_BITS-1:0] counts [MAX_SAMPLES*NUM_ANCESTRIES];
    logic [TOT_BITS-1:0]   totals [MAX_SAMPLES];
    logic [SITE_BITS-1:0]  seen, used, skipped;
    logic [THIN_BITS-1:0]  thin_phase, thin_interval;
    logic [LIM_BITS-1:0]   anc_in_use;
    bit                    site_active;
    tally_result_t         pending_results[$];
    int                    errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      foreach (totals[i]) totals[i] = '0;
      seen = '0;
      used = '0;
      skipped = '0;
      thin_phase = '0;
      thin_interval = 16'd1;
      anc_in_use = 4'd8;
      site_active = 1'b0;
      errors = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_THIN_INTERVAL: thin_interval = v;
        REG_ANC_IN_USE:    anc_in_use = v[LIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task note_call(bit rd, logic [IN_BITS-1:0] d);
      logic                    st, row;
      logic [9:0]              smp;
      logic [4:0]              fa, fb;
      int                      a1, a2, lim, ti, nxt, base;
      logic [CNT_IDX_BITS-1:0] i1, i2;
      tally_result_t           r;
      st  = d[0];
      row = d[1];
      smp = d[11:2];
      fa  = d[16:12];
      fb  = d[21:17];
      a1  = int'(fa[3:0]);
      a2  = int'(fb[3:0]);
      lim = (anc_in_use > NUM_ANCESTRIES) ? NUM_ANCESTRIES : int'(anc_in_use);
      ti  = (thin_interval == 0) ? 1 : int'(thin_interval);
      base = int'(smp) * NUM_ANCESTRIES;
      i1 = CNT_IDX_BITS'(base + a1);
      i2 = CNT_IDX_BITS'(base + a2);
      r.count = '0;
      if (rd) begin
        if (!fa[4] && a1 < lim) begin
          r.status = ST_READ;
          r.count = counts[i1];
        end else begin
          r.status = ST_TOO_BIG;
        end
      end else begin
        if (st) begin
          seen = bump(seen);
          site_active = (thin_phase == 0) && row;
          if (site_active) used = bump(used);
          nxt = int'(thin_phase) + 1;
          thin_phase = (nxt >= ti) ? '0 : THIN_BITS'(nxt);
        end
        if (!site_active) begin
          r.status = (ti > 1 && thin_phase != 1) ? ST_THINNED : ST_ROW_ABS;
        end else if (fa[4] || fb[4]) begin
          r.status = ST_MISSING;
          skipped = bump(skipped);
        end else if (a1 >= lim || a2 >= lim) begin
          r.status = ST_TOO_BIG;
          skipped = bump(skipped);
        end else begin
          r.status = ST_COUNTED;
          counts[i1] = bump(counts[i1]);
          counts[i2] = bump(counts[i2]);
          totals[smp] = (totals[smp] >= {TOT_BITS{1'b1}} - 1) ? {TOT_BITS{1'b1}}
                                                              : totals[smp] + 2;
          r.count = counts[i1];
        end
      end
      r.total   = totals[smp];
      r.seen    = seen;
      r.used    = used;
      r.skipped = skipped;
      pending_results.insert(pending_results.size(), r);
    endtask

    task cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check(logic [2:0] st, logic [OUT_BITS-1:0] d);
      tally_result_t w;
      if (pending_results.size() == 0) begin
        report("result item with no prediction waiting");
      end else begin
        w = pending_results.pop_front();
        cmp_field("status", 64'(st), 64'(w.status));
        cmp_field("allele_count", 64'(d[31:0]), 64'(w.count));
        cmp_field("called_total", 64'(d[64:32]), 64'(w.total));
        cmp_field("sites_seen", 64'(d[96:65]), 64'(w.seen));
        cmp_field("sites_used", 64'(d[128:97]), 64'(w.used));
        cmp_field("skipped_calls", 64'(d[160:129]), 64'(w.skipped));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;
  logic [2:0]          m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  tally_scoreboard sb;
  int  cycle_count = 0;
  bit  hold_req = 1'b0;
  bit  rx_idle_on = 1'b1;
  bit  tx_idle_on = 1'b1;
  int  cur_lim = NUM_ANCESTRIES;

  ancestry_call_tally_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ancestry_call_tally_top");
      $finish;
    end
  end

  // monitors
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_call(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check(m_tuser, m_tdata);
    if (!rst && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  function automatic int rand_gap();
    return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                      : int'($urandom_range(12, 60));
  endfunction

  // receiver
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = rand_gap() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_BITS-1:0] pack_call(bit st, bit row, logic [9:0] smp,
                                                   logic [4:0] fa, logic [4:0] fb);
    return {2'b00, fb, fa, smp, row, st};
  endfunction

  task push_item(bit rd, logic [IN_BITS-1:0] d);
    s_tuser  <= rd;
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (rand_gap()) @(posedge clk);
    end
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_config(logic [15:0] thin, logic [3:0] anc);
    wait_drained();
    write_reg(REG_THIN_INTERVAL, thin);
    write_reg(REG_ANC_IN_USE, 16'(anc));
    cur_lim = (anc > NUM_ANCESTRIES) ? NUM_ANCESTRIES : int'(anc);
  endtask

  function automatic logic [9:0] pick_sample();
    if ($urandom_range(0, 3) != 0)
      return $urandom_range(0, 1) ? 10'($urandom_range(0, 5)) : 10'($urandom_range(1018, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [4:0] pick_anc();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {1'b1, 4'($urandom_range(0, 15))};
    if (r == 1 || cur_lim == 0) return 5'($urandom_range(0, 15));
    return 5'($urandom_range(0, cur_lim - 1));
  endfunction

  task directed_items();
    push_item(1'b0, pack_call(0, 0, 10'd5, 5'd0, 5'd1));
    push_item(1'b0, pack_call(1, 0, 10'd5, 5'd0, 5'd1));
    push_item(1'b0, pack_call(1, 1, 10'd1023, 5'd7, 5'd7));
    push_item(1'b0, pack_call(0, 0, 10'd0, 5'd0, 5'd7));
    push_item(1'b0, pack_call(0, 1, 10'd0, 5'd0, 5'd0));
    push_item(1'b0, pack_call(0, 1, 10'd0, 5'h1F, 5'd2));
    push_item(1'b0, pack_call(0, 1, 10'd0, 5'd3, 5'h10));
    push_item(1'b0, pack_call(0, 1, 10'd0, 5'h10, 5'h1F));
    push_item(1'b0, pack_call(0, 1, 10'd0, 5'd8, 5'd1));
    push_item(1'b0, pack_call(0, 1, 10'd0, 5'd1, 5'd15));
    push_item(1'b1, pack_call(0, 0, 10'd1023, 5'd7, 5'd0));
    push_item(1'b1, pack_call(1, 0, 10'd0, 5'd0, 5'h1F));
    push_item(1'b1, pack_call(0, 1, 10'd0, 5'h1F, 5'd0));
    push_item(1'b1, pack_call(0, 0, 10'd0, 5'd8, 5'd0));
    push_item(1'b1, pack_call(0, 0, 10'd1023, 5'd15, 5'd15));
    push_item(1'b1, pack_call(0, 0, 10'd512, 5'h10, 5'd0));
    set_config(16'd3, 4'd2);
    push_item(1'b0, pack_call(1, 1, 10'd1, 5'd1, 5'd0));
    push_item(1'b0, pack_call(1, 1, 10'd1, 5'd1, 5'd0));
    push_item(1'b0, pack_call(1, 1, 10'd1, 5'd0, 5'd0));
    push_item(1'b0, pack_call(1, 1, 10'd1, 5'd0, 5'd1));
    push_item(1'b0, pack_call(0, 1, 10'd1, 5'd2, 5'd0));
    push_item(1'b1, pack_call(0, 0, 10'd1, 5'd2, 5'd0));
  endtask

  task random_items(int n);
    int sent, r, k;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k = $urandom_range(1, 8);
        push_item(1'b0, pack_call(1, $urandom_range(0, 9) != 0, pick_sample(),
                                  pick_anc(), pick_anc()));
        for (int i = 1; i < k; i++)
          push_item(1'b0, pack_call(0, 1'($urandom_range(0, 1)), pick_sample(),
                                    pick_anc(), pick_anc()));
        sent += k;
      end else if (r < 88) begin
        push_item(1'b1, pack_call(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  pick_sample(), pick_anc(), 5'($urandom_range(0, 31))));
        sent++;
      end else begin
        push_item(1'($urandom_range(0, 1)), IN_BITS'($urandom_range(0, 32'h3FFFFF)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] thin_set [8];
    logic [3:0]  anc_set [8];
    sb = new();
    thin_set = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd2, 16'd1, 16'd5, 16'd7};
    anc_set  = '{4'd8, 4'd4, 4'd15, 4'd1, 4'd0, 4'd8, 4'd6, 4'd2};
    thin_set[6] = 16'($urandom_range(1, 6));
    anc_set[6]  = 4'($urandom_range(1, 8));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_THIN_INTERVAL, 16'd1);
    write_reg(REG_ANC_IN_USE, 16'd8);
    directed_items();
    for (int p = 0; p < 8; p++) begin
      set_config(thin_set[p], anc_set[p]);
      rx_idle_on = (p % 3 != 1);
      tx_idle_on = (p % 3 != 1);
      if (p == 2) begin
        // receiver holds off while the sender keeps offering
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
          push_item(1'b0, pack_call(i == 0, 1, pick_sample(), pick_anc(), pick_anc()));
        tx_idle_on = 1'b1;
      end
      random_items(PHASE_ITEMS);
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS ancestry_call_tally_top");
    end else begin
      $display("FAIL ancestry_call_tally_top");
    end
    $finish;
  end

endmodule
